// File: hdl/lstf_pkg.sv
package lstf_pkg;

  // Signed range of the result; quotients beyond it saturate.
  localparam int unsigned DataWidth = 32;

  localparam int unsigned RawW     = 32;
  localparam int unsigned OutW     = 32;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned FracW    = 5;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  // Datapath widths. The product of a 33-bit difference and a 16-bit factor
  // has a magnitude of at most 2^47, and the fraction shift adds up to 31 bits.
  localparam int unsigned DiffW = RawW + 1;
  localparam int unsigned ProdW = DiffW + ScaleW;
  localparam int unsigned MagW  = ProdW - 1;
  localparam int unsigned NumW  = MagW + (1 << FracW) - 1;
  localparam int unsigned ThrW  = ScaleW + DataWidth;
  localparam int unsigned QuotW = DataWidth;

  // Long division: quotient bits resolved per divider stage.
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned DivStages     = QuotW / StepsPerStage;

  localparam logic [CfgIdxW-1:0] RegOffset   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegScaleNum = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegScaleDen = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegFracBits = CfgIdxW'(3);

  typedef enum logic [StatusW-1:0] {
    StatusOk      = StatusW'(0),
    StatusSat     = StatusW'(1),
    StatusDenZero = StatusW'(2)
  } status_e;

  typedef struct packed {
    logic [RawW-1:0]   offset;
    logic [ScaleW-1:0] num;
    logic [ScaleW-1:0] den_mag;
    logic              den_neg;
    logic              den_zero;
    logic [FracW-1:0]  frac;
  } cfg_t;

  typedef struct packed {
    logic              neg;
    logic              sat;
    logic              dz;
    logic [ScaleW-1:0] rem;
    logic [QuotW-1:0]  qn;
  } div_req_t;

endpackage

// File: hdl/lstf_cfg.sv
module lstf_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lstf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lstf_pkg::CfgDataW-1:0]   cfg_data_i,
  output lstf_pkg::cfg_t                  cfg_o
);

  lstf_pkg::cfg_t cfg_q, cfg_d;
  logic [lstf_pkg::ScaleW-1:0] den_val;

  assign cfg_ready_o = 1'b1;
  assign den_val     = cfg_data_i[lstf_pkg::ScaleW-1:0];

  // The divisor is kept as sign and magnitude so the datapath never negates it.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lstf_pkg::RegOffset: begin
          cfg_d.offset = cfg_data_i[lstf_pkg::RawW-1:0];
        end
        lstf_pkg::RegScaleNum: begin
          cfg_d.num = cfg_data_i[lstf_pkg::ScaleW-1:0];
        end
        lstf_pkg::RegScaleDen: begin
          cfg_d.den_neg  = den_val[lstf_pkg::ScaleW-1];
          cfg_d.den_mag  = den_val[lstf_pkg::ScaleW-1] ? -den_val : den_val;
          cfg_d.den_zero = (den_val == '0);
        end
        lstf_pkg::RegFracBits: begin
          cfg_d.frac = cfg_data_i[lstf_pkg::FracW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset   <= '0;
      cfg_q.num      <= lstf_pkg::ScaleW'(1);
      cfg_q.den_mag  <= lstf_pkg::ScaleW'(1);
      cfg_q.den_neg  <= 1'b0;
      cfg_q.den_zero <= 1'b0;
      cfg_q.frac     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/lstf_front.sv
module lstf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lstf_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lstf_pkg::RawW-1:0]    raw_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lstf_pkg::div_req_t           out_o
);

  localparam int unsigned NStages = 5;

  logic [NStages-1:0] valid_q, valid_d, ready, vin, en;

  logic signed [lstf_pkg::RawW-1:0]   raw_s, off_s;
  logic signed [lstf_pkg::ScaleW-1:0] num_s;

  logic signed [lstf_pkg::DiffW-1:0] diff_d, diff_q;
  logic signed [lstf_pkg::ProdW-1:0] prod_d, prod_q;
  logic                              neg3_d, neg3_q, neg4_q;
  logic [lstf_pkg::MagW-1:0]         mag_d, mag_q;
  logic [lstf_pkg::NumW-1:0]         num_d, num_q;
  logic [lstf_pkg::ThrW-1:0]         thr_d, thr_q;
  lstf_pkg::div_req_t                req_d, req_q;

  // Each stage moves on when the stage after it is empty or moving.
  always_comb begin
    vin = {valid_q[NStages-2:0], in_valid_i};
    ready[NStages-1] = !valid_q[NStages-1] || out_ready_i;
    for (int k = NStages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k + 1];
    end
    for (int k = 0; k < NStages; k++) begin
      valid_d[k] = ready[k] ? vin[k] : valid_q[k];
    end
    en = ready & vin;
  end

  assign raw_s = raw_i;
  assign off_s = cfg_i.offset;
  assign num_s = cfg_i.num;

  // Stage 1: offset correction. Stage 2: scale multiply.
  assign diff_d = lstf_pkg::DiffW'(raw_s) - lstf_pkg::DiffW'(off_s);
  assign prod_d = lstf_pkg::ProdW'(diff_q) * lstf_pkg::ProdW'(num_s);

  // Stage 3: sign and magnitude of the quotient.
  assign neg3_d = prod_q[lstf_pkg::ProdW-1] ^ cfg_i.den_neg;
  assign mag_d  = lstf_pkg::MagW'(prod_q[lstf_pkg::ProdW-1] ? -prod_q : prod_q);

  // Stage 4: append the fraction bits and form the saturation threshold. The
  // quotient overflows exactly when the dividend reaches (limit + 1) * divisor.
  always_comb begin
    num_d = lstf_pkg::NumW'(mag_q) << cfg_i.frac;
    thr_d = (lstf_pkg::ThrW'(cfg_i.den_mag) << (lstf_pkg::DataWidth - 1))
          + (neg3_q ? lstf_pkg::ThrW'(cfg_i.den_mag) : '0);
  end

  // Stage 5: overflow compare and divider set-up. Without overflow the top
  // part of the dividend is already smaller than the divisor.
  always_comb begin
    req_d.neg = neg4_q;
    req_d.sat = (num_q >= lstf_pkg::NumW'(thr_q));
    req_d.dz  = cfg_i.den_zero;
    req_d.rem = num_q[lstf_pkg::QuotW +: lstf_pkg::ScaleW];
    req_d.qn  = num_q[lstf_pkg::QuotW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      diff_q <= diff_d;
    end
    if (en[1]) begin
      prod_q <= prod_d;
    end
    if (en[2]) begin
      neg3_q <= neg3_d;
      mag_q  <= mag_d;
    end
    if (en[3]) begin
      neg4_q <= neg3_q;
      num_q  <= num_d;
      thr_q  <= thr_d;
    end
    if (en[4]) begin
      req_q <= req_d;
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NStages-1];
  assign out_o       = req_q;

  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NStages-1] && !out_ready_i |=> valid_q[NStages-1] && $stable(req_q))
    else $error("front end dropped or changed a stalled item");

endmodule

// File: hdl/lstf_div.sv
module lstf_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lstf_pkg::ScaleW-1:0]    den_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  lstf_pkg::div_req_t             in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lstf_pkg::div_req_t             out_o
);

  localparam int unsigned NStages = lstf_pkg::DivStages;

  logic [NStages-1:0] valid_q, valid_d, ready, vin, en;
  lstf_pkg::div_req_t stage_d [NStages];
  lstf_pkg::div_req_t stage_q [NStages];

  // Restoring long division. The dividend bits leave the top of qn while the
  // quotient bits enter at the bottom; the remainder stays below the divisor.
  function automatic lstf_pkg::div_req_t div_steps(lstf_pkg::div_req_t a,
                                                   logic [lstf_pkg::ScaleW-1:0] den);
    lstf_pkg::div_req_t r;
    logic [lstf_pkg::ScaleW:0] t;
    r = a;
    for (int s = 0; s < lstf_pkg::StepsPerStage; s++) begin
      t = {r.rem, r.qn[lstf_pkg::QuotW-1]};
      if (t >= {1'b0, den}) begin
        t    = t - {1'b0, den};
        r.qn = {r.qn[lstf_pkg::QuotW-2:0], 1'b1};
      end else begin
        r.qn = {r.qn[lstf_pkg::QuotW-2:0], 1'b0};
      end
      r.rem = t[lstf_pkg::ScaleW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    vin = {valid_q[NStages-2:0], in_valid_i};
    ready[NStages-1] = !valid_q[NStages-1] || out_ready_i;
    for (int k = NStages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k + 1];
    end
    for (int k = 0; k < NStages; k++) begin
      valid_d[k] = ready[k] ? vin[k] : valid_q[k];
    end
    en = ready & vin;
  end

  always_comb begin
    stage_d[0] = div_steps(in_i, den_i);
    for (int k = 1; k < NStages; k++) begin
      stage_d[k] = div_steps(stage_q[k - 1], den_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NStages; k++) begin
      if (en[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NStages-1];
  assign out_o       = stage_q[NStages-1];

  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NStages-1] && !out_ready_i |=> valid_q[NStages-1] && $stable(out_o))
    else $error("divider dropped or changed a stalled item");

endmodule

// File: hdl/linear_scale_to_fixed_point.sv
// Scales each signed 32-bit raw sample to a signed fixed-point number:
// fixed_value = trunc((raw_value - offset) * scale_numerator * 2^frac_bits /
// scale_denominator), rounded toward zero and computed exactly. A quotient
// outside the signed 32-bit range is clamped to the nearest bound with status
// 1; a zero denominator gives a result of zero with status 2. The block takes
// one item per clock when the output is not stalled and passes it through
// five front-end stages (offset subtract, 33x16 multiply, magnitude, fraction
// shift, overflow compare), an eight-stage restoring divider that resolves
// four quotient bits per stage, and an output register that sets sign and
// status. The divider is the deepest part of the pipeline. Each stage holds
// its item when the next one is full, so a stalled output only blocks the
// input once the pipeline is full. The four registers are written through
// the configuration channel, which is always ready; they may only change
// while no item is in flight, because the stages read them directly.
module linear_scale_to_fixed_point (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lstf_pkg::RawW-1:0]         s_axis_tdata,   // raw_value

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lstf_pkg::OutW-1:0]         m_axis_tdata,   // fixed_value
  output logic [lstf_pkg::StatusW-1:0]      m_axis_tuser,   // status

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lstf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [lstf_pkg::CfgDataW-1:0]     cfg_data_i
);

  // Clamp values of the result, sign-extended to one bit above the quotient width.
  localparam logic signed [lstf_pkg::QuotW:0] PosRes =
    {2'b00, {(lstf_pkg::QuotW - 1){1'b1}}};
  localparam logic signed [lstf_pkg::QuotW:0] NegRes =
    {2'b11, {(lstf_pkg::QuotW - 1){1'b0}}};

  lstf_pkg::cfg_t     cfg;
  logic               front_valid, front_ready;
  lstf_pkg::div_req_t front_req;
  logic               div_valid, div_ready;
  lstf_pkg::div_req_t div_out;

  logic                              out_valid_q, out_valid_d;
  logic [lstf_pkg::OutW-1:0]         fixed_q, fixed_d;
  lstf_pkg::status_e                 status_q, status_d;
  logic signed [lstf_pkg::QuotW:0]   q_ext, res_s;

  lstf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lstf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .raw_i       (s_axis_tdata),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_o       (front_req)
  );

  lstf_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .den_i       (cfg.den_mag),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_i        (front_req),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_o       (div_out)
  );

  // Output register: it frees up whenever its item is taken, so the divider
  // keeps moving while the consumer reads every cycle.
  assign div_ready = !out_valid_q || m_axis_tready;

  // A zero denominator wins over overflow; either replaces the negated quotient.
  always_comb begin
    out_valid_d = div_ready ? div_valid : out_valid_q;
    q_ext       = {1'b0, div_out.qn};
    status_d    = lstf_pkg::StatusOk;
    res_s       = div_out.neg ? -q_ext : q_ext;
    priority if (div_out.dz) begin
      status_d = lstf_pkg::StatusDenZero;
      res_s    = '0;
    end else if (div_out.sat) begin
      status_d = lstf_pkg::StatusSat;
      res_s    = div_out.neg ? NegRes : PosRes;
    end
    fixed_d = lstf_pkg::OutW'(res_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ready && div_valid) begin
      fixed_q  <= fixed_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = fixed_q;
  assign m_axis_tuser  = status_q;

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == lstf_pkg::StatusDenZero) |-> m_axis_tdata == '0)
    else $error("zero denominator gave a nonzero result");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == lstf_pkg::StatusSat) |->
      (m_axis_tdata == lstf_pkg::OutW'(PosRes)) || (m_axis_tdata == lstf_pkg::OutW'(NegRes)))
    else $error("saturated result is not a range bound");

endmodule

// File: tb/lstf_checker.sv
`timescale 1ns / 100ps

// Watches the configuration, input and output channels of the scaler. It
// keeps its own copy of the four registers, works out the scaled value and the
// status for every accepted raw sample, and compares each accepted result,
// field by field, against the oldest expected one.
module lstf_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [lstf_pkg::RawW-1:0]       s_axis_tdata,    // raw_value

  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [lstf_pkg::OutW-1:0]       m_axis_tdata,    // fixed_value
  input  logic [lstf_pkg::StatusW-1:0]    m_axis_tuser,    // status

  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [lstf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lstf_pkg::CfgDataW-1:0]   cfg_data_i,

  output int unsigned                     results_seen_o,
  output int unsigned                     fail_count_o
);

  typedef struct {
    logic [lstf_pkg::OutW-1:0] value;
    lstf_pkg::status_e         status;
  } scaled_t;

  scaled_t pending_scaled[$];

  logic signed [lstf_pkg::RawW-1:0]   cur_offset;
  logic signed [lstf_pkg::ScaleW-1:0] cur_num;
  logic signed [lstf_pkg::ScaleW-1:0] cur_den;
  logic [lstf_pkg::FracW-1:0]         cur_frac;

  int unsigned n_seen;
  int unsigned n_fail;

  // Exact truncating division of (raw - offset) * num * 2^frac by den. The
  // fraction bits are brought in one at a time so the quotient never grows
  // past the saturation limit by more than one bit.
  function automatic scaled_t scale_sample(input logic [lstf_pkg::RawW-1:0] raw);
    scaled_t           res;
    longint            diff;
    longint            prod;
    longint unsigned   mag;
    longint unsigned   dmag;
    longint unsigned   quo;
    longint unsigned   rem;
    longint unsigned   limit;
    longint unsigned   signed_quo;
    bit                neg;
    bit                sat;
    int                i;

    if (cur_den == '0) begin
      res.value  = '0;
      res.status = lstf_pkg::StatusDenZero;
      return res;
    end

    diff  = longint'($signed(raw)) - longint'(cur_offset);
    prod  = diff * longint'(cur_num);
    neg   = (prod < 0) != (cur_den < 0);
    mag   = (prod < 0) ? longint'(-prod) : prod;
    dmag  = (cur_den < 0) ? -longint'(cur_den) : longint'(cur_den);
    limit = neg ? (64'd1 << (lstf_pkg::DataWidth - 1))
                : (64'd1 << (lstf_pkg::DataWidth - 1)) - 64'd1;

    quo = mag / dmag;
    rem = mag % dmag;
    sat = quo > limit;
    for (i = 0; i < int'(cur_frac) && !sat; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= dmag) begin
        rem = rem - dmag;
        quo = quo | 64'd1;
      end
      if (quo > limit) sat = 1'b1;
    end

    if (sat) quo = limit;
    signed_quo = neg ? (64'd0 - quo) : quo;
    res.value  = signed_quo[lstf_pkg::OutW-1:0];
    res.status = sat ? lstf_pkg::StatusSat : lstf_pkg::StatusOk;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scaled_t want;
    if (!rst_ni) begin
      cur_offset = '0;
      cur_num    = lstf_pkg::ScaleW'(1);
      cur_den    = lstf_pkg::ScaleW'(1);
      cur_frac   = '0;
      pending_scaled.delete();
      n_seen = 0;
      n_fail = 0;
      results_seen_o <= 0;
      fail_count_o   <= 0;
    end else begin
      // Register writes; an index outside the map changes nothing.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          lstf_pkg::RegOffset:   cur_offset = cfg_data_i[lstf_pkg::RawW-1:0];
          lstf_pkg::RegScaleNum: cur_num    = cfg_data_i[lstf_pkg::ScaleW-1:0];
          lstf_pkg::RegScaleDen: cur_den    = cfg_data_i[lstf_pkg::ScaleW-1:0];
          lstf_pkg::RegFracBits: cur_frac   = cfg_data_i[lstf_pkg::FracW-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        pending_scaled.push_back(scale_sample(s_axis_tdata));
      end

      if (m_axis_tvalid && m_axis_tready) begin
        n_seen++;
        if (pending_scaled.size() == 0) begin
          $error("unexpected result item: fixed_value %0d, status %0d",
                 $signed(m_axis_tdata), m_axis_tuser);
          n_fail++;
        end else begin
          want = pending_scaled.pop_front();
          if (m_axis_tdata !== want.value) begin
            $error("fixed_value mismatch: expected %0d, actual %0d",
                   $signed(want.value), $signed(m_axis_tdata));
            n_fail++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, m_axis_tuser);
            n_fail++;
          end
        end
      end

      results_seen_o <= n_seen;
      fail_count_o   <= n_fail;
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

// Top of the scaler testbench. It makes the clock and the single reset, drives
// the configuration channel and the raw sample stream, plays the receiver on
// the result stream, and gives the verdict. All prediction and comparison is
// done by the checker instantiated next to the block.
module tb;

  // Index that maps to no register; a write to it must change nothing.
  localparam logic [lstf_pkg::CfgIdxW-1:0] RegUnused = '1;

  // Cycles without any accepted item before the run is declared hung. The
  // longest correct quiet stretch is the receiver hold-off below plus the
  // pipeline depth, far below this.
  localparam int unsigned IdleLimit = 2000;

  // After this many results the receiver stops taking items for a long time,
  // so the pipeline fills up and the input stalls.
  localparam int unsigned PressureAt   = 300;
  localparam int unsigned PressureHold = 120;

  // Wait at the end, after the last drain, to catch anything stray.
  localparam int unsigned SettleCycles = 24;

  localparam int unsigned RandomPhases   = 10;
  localparam int unsigned ItemsPerPhase  = 85;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;

  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [lstf_pkg::RawW-1:0]          s_axis_tdata = '0;     // raw_value

  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [lstf_pkg::OutW-1:0]          m_axis_tdata;          // fixed_value
  logic [lstf_pkg::StatusW-1:0]       m_axis_tuser;          // status

  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [lstf_pkg::CfgIdxW-1:0]       cfg_index_i = '0;
  logic [lstf_pkg::CfgDataW-1:0]      cfg_data_i = '0;

  int unsigned results_seen;
  int unsigned fail_count;

  // Sender bookkeeping: samples accepted so far and whether the sender is in
  // a stretch with no gaps between items.
  int unsigned raw_sent = 0;
  bit          tx_burst = 1'b0;

  // Offset of the current setting, used to aim samples near the zero point.
  logic [lstf_pkg::RawW-1:0] phase_offset;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  linear_scale_to_fixed_point dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  lstf_checker scale_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .results_seen_o (results_seen),
    .fail_count_o   (fail_count)
  );

  // One register write. Valid is left high so that back-to-back writes never
  // lower and raise it in the same step; the caller lowers it after a batch.
  task automatic cfg_write(input logic [lstf_pkg::CfgIdxW-1:0]  idx,
                           input logic [lstf_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Writes all four registers. The upper bits of the narrow registers carry
  // random junk, which the block must ignore. Optionally a write to an
  // unmapped index follows, which must leave the setting untouched.
  task automatic configure(input logic [31:0] ofs, input logic [15:0] num,
                           input logic [15:0] den, input logic [4:0] frac,
                           input bit poke_unused);
    cfg_write(lstf_pkg::RegOffset, ofs);
    cfg_write(lstf_pkg::RegScaleNum, {16'($urandom), num});
    cfg_write(lstf_pkg::RegScaleDen, {16'($urandom), den});
    cfg_write(lstf_pkg::RegFracBits, {27'($urandom), frac});
    if (poke_unused) cfg_write(RegUnused, $urandom);
    cfg_valid_i  <= 1'b0;
    phase_offset = ofs;
  endtask

  // Offers one raw sample after a random gap and returns at the edge where it
  // is taken. Valid stays high when no gap follows, so the stream can run at
  // one item per cycle.
  task automatic send_raw(input logic [lstf_pkg::RawW-1:0] value);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    raw_sent++;
    if (raw_sent % 32 == 0) tx_burst = ($urandom_range(0, 3) == 0);
  endtask

  // Setting changes are only made with nothing in flight, since the stages
  // read the registers directly. Every sample yields exactly one result, so
  // the block is idle once the result count has caught up.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (results_seen < raw_sent) @(posedge clk_i);
  endtask

  // Random 16-bit scale factor, weighted toward the extremes and toward the
  // trivial values.
  function automatic logic [15:0] pick_scale(input bit allow_zero);
    case ($urandom_range(0, 9))
      0:       return allow_zero ? 16'h0000 : 16'h0001;
      1:       return 16'h8000;
      2:       return 16'h7fff;
      3:       return ($urandom_range(0, 1) != 0) ? 16'h0001 : 16'hffff;
      4:       return 16'($urandom_range(0, 64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // Raw sample for the random part: four in ten close to the offset, where results
  // stay in range, the rest anywhere in the field or at its ends.
  function automatic logic [lstf_pkg::RawW-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      1, 2, 3: return phase_offset + 32'($urandom_range(0, 4000)) - 32'd2000;
      4:       return phase_offset + 32'($urandom_range(0, 200000)) - 32'd100000;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: a random wait before each result, with stretches of none, and
  // one long hold-off while the sender keeps going.
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          rx_burst;
    taken    = 0;
    rx_burst = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 9);
      if (taken == PressureAt) stall = PressureHold;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
      if (taken % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog: ends the run if nothing is accepted on any channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    logic [31:0] ofs;
    logic [4:0]  frac;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    phase_offset = '0;

    // Reset setting (offset 0, factor 1 over 1, no fraction bits): the ends
    // of the sample range must pass straight through.
    send_raw(32'h8000_0000);
    send_raw(32'h7fff_ffff);
    send_raw(32'h0000_0000);
    send_raw(32'hffff_ffff);
    send_raw(32'h0000_0001);
    drain();

    // One below the most negative result saturates; one above lands exactly
    // on the negative bound without saturating. The unmapped write must not
    // disturb the setting.
    configure(32'd1, 16'd1, 16'd1, 5'd0, 1'b1);
    send_raw(32'h8000_0000);
    send_raw(32'h8000_0001);
    drain();

    // Largest product magnitude: widest difference times the most negative
    // factor over the most negative divisor, with sixteen fraction bits.
    configure(32'h7fff_ffff, 16'h8000, 16'h8000, 5'd16, 1'b0);
    send_raw(32'h8000_0000);
    send_raw(32'h7fff_ffff);
    drain();

    // Zero divisor: result zero, flagged, whatever the sample.
    configure(32'd0, 16'd5, 16'd0, 5'd3, 1'b0);
    send_raw(32'h8000_0000);
    send_raw(32'd12345);
    send_raw(32'h7fff_ffff);
    drain();

    // Uneven division on both sides of zero checks truncation toward zero.
    configure(32'd0, 16'd3, 16'd7, 5'd4, 1'b0);
    send_raw(32'hffff_fffb);
    send_raw(32'd5);
    send_raw(32'hffff_ffff);
    send_raw(32'd1000);
    drain();

    // Fraction count beyond sixteen is accepted; anything but a zero
    // difference saturates.
    configure(32'hffff_ff9c, 16'h7fff, 16'hffff, 5'd31, 1'b1);
    send_raw(32'hffff_ff9c);
    send_raw(32'hffff_ff9d);
    drain();

    // Random settings, each followed by a batch of samples.
    for (phase = 0; phase < RandomPhases; phase++) begin
      case ($urandom_range(0, 3))
        0:       ofs = '0;
        1:       ofs = 32'($urandom_range(0, 2000)) - 32'd1000;
        default: ofs = $urandom;
      endcase
      frac = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                         : 5'($urandom_range(0, 16));
      configure(ofs, pick_scale(1'b0), pick_scale(1'b1), frac, $urandom_range(0, 3) == 0);
      for (n = 0; n < ItemsPerPhase; n++) begin
        send_raw(pick_raw());
      end
      drain();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
